// ===== rtl/rlts_pkg.sv =====
// ----------------------------------------------------------------------------
// rlts_pkg
// Shared sizes, mode and status codes, item types and the control/status
// bundles between the rotating list controller and its datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlts_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);      // entry address
    localparam int LW    = $clog2(DEPTH + 1);  // length, 0 .. DEPTH
    localparam int MW    = AW + 1;             // memory address with bank bit
    localparam int DW    = 32;
    localparam int CNT_W = 16;
    localparam int SW    = $clog2(CNT_W);
    localparam int CFG_W = 7;
    localparam int IDX_W = 6;
    localparam int POS_W = 6;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_ROT_R = 3'd1;
    localparam logic [2:0] MODE_ROT_L = 3'd2;
    localparam logic [2:0] MODE_ROT_N = 3'd3;
    localparam logic [2:0] MODE_DEL   = 3'd4;
    localparam logic [2:0] MODE_SRCH  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]        mode;
        logic [IDX_W-1:0]  index;
        logic signed [DW-1:0] value;
        logic [CNT_W-1:0]  rotate_count;
    } rlts_in_t;

    typedef struct packed {
        logic signed [DW-1:0] removed_value;
        logic [POS_W-1:0]  position;
        logic              found;
        logic [1:0]        status;
    } rlts_out_t;

    typedef struct packed {
        logic load;
        logic wr_entry;
        logic k_direct;
        logic mod_start;
        logic k_from_mod;
        logic rot_read;
        logic bank_flip;
        logic del_step;
        logic len_dec;
        logic srch_step;
        logic hit_capture;
        logic swap_a;
        logic swap_b;
        logic finish;
    } rlts_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] code;
        logic       mod_done;
        logic       k_zero;
        logic       rot_last;
        logic       del_last;
        logic       hit;
        logic       hit_front;
        logic       srch_end;
    } rlts_stat_t;

endpackage

// ===== rtl/rlts_mod.sv =====
// ----------------------------------------------------------------------------
// rlts_mod
// Iterative remainder unit: rotate count modulo list length, one dividend
// bit per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlts_mod import rlts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] dividend,
    input  logic [LW-1:0]    divisor,
    output logic             done,
    output logic [AW-1:0]    remainder
);

    logic             run_reg;
    logic             done_reg;
    logic [SW-1:0]    step_reg;
    logic [CNT_W-1:0] shift_reg;
    logic [LW-1:0]    rem_reg;
    logic [LW-1:0]    rem_next;
    logic [LW:0]      trial;
    logic [LW:0]      trial_sub;

    always_comb
    begin
        trial     = {rem_reg, shift_reg[CNT_W-1]};
        trial_sub = trial - (LW+1)'(divisor);
        if (trial >= (LW+1)'(divisor))
        begin
            rem_next = trial_sub[LW-1:0];
        end
        else
        begin
            rem_next = trial[LW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(CNT_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (run_reg)
        begin
            shift_reg <= {shift_reg[CNT_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[AW-1:0];

endmodule

// ===== rtl/rlts_datapath.sv =====
// ----------------------------------------------------------------------------
// rlts_datapath
// Entry store (two banks, one write and one read port), length, walk
// pointer, rotate amount and result register of the rotating list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlts_datapath import rlts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  rlts_in_t         op,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  rlts_cmd_t        cmd,
    output rlts_stat_t       stat,
    output logic             result_valid,
    output rlts_out_t        result
);

    logic [DW-1:0]      mem [2*DEPTH];
    logic [2*DEPTH-1:0] valid_reg;

    rlts_in_t      op_reg;
    logic [1:0]    code_reg;
    logic [1:0]    code_next;
    logic [LW-1:0] length_reg;
    logic [LW-1:0] ptr_reg;
    logic          bank_reg;
    logic [AW-1:0] k_reg;
    logic [DW-1:0] rd_data_reg;
    logic          rd_ok_reg;
    logic          pend_reg;
    logic          pend_zero_reg;
    logic [MW-1:0] pend_addr_reg;
    logic          cap_reg;
    logic [DW-1:0] removed_reg;
    logic          chk_reg;
    logic [AW-1:0] chk_addr_reg;
    logic [AW-1:0] hit_addr_reg;
    logic [DW-1:0] prev_reg;
    logic          found_reg;
    logic [AW-1:0] pos_reg;
    logic          strobe_reg;
    rlts_out_t     result_reg;

    logic [DW-1:0] rd_out;
    logic          in_range;
    logic          rd_en;
    logic [MW-1:0] rd_addr;
    logic          wr_en;
    logic [MW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [LW-1:0] ptr_dec;
    logic [LW-1:0] len_dec;
    logic [LW:0]   rot_sum;
    logic [LW:0]   rot_wrap;
    logic [LW:0]   rot_dst_full;
    logic [AW-1:0] rot_dst;
    logic [AW-1:0] hit_dec;
    logic [AW-1:0] chk_dec;
    logic [AW-1:0] k_dir;
    logic          mod_done;
    logic [AW-1:0] mod_rem;
    logic          hit;

    rlts_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (op_reg.rotate_count),
        .divisor   (length_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        rd_out   = rd_ok_reg ? rd_data_reg : '0;
        in_range = ptr_reg < length_reg;
        rd_en    = cmd.rot_read | ((cmd.del_step | cmd.srch_step) & in_range);
        rd_addr  = {bank_reg, ptr_reg[AW-1:0]};
        ptr_dec  = ptr_reg - LW'(1);
        len_dec  = length_reg - LW'(1);
        hit_dec  = hit_addr_reg - AW'(1);
        chk_dec  = chk_addr_reg - AW'(1);
        hit      = chk_reg && (rd_out == op_reg.value);

        // destination of entry ptr after rotating right by k within the length
        rot_sum  = (LW+1)'(ptr_reg) + (LW+1)'(k_reg);
        rot_wrap = rot_sum - (LW+1)'(length_reg);
        if (!in_range)
        begin
            rot_dst_full = (LW+1)'(ptr_reg);
        end
        else if (rot_sum >= (LW+1)'(length_reg))
        begin
            rot_dst_full = rot_wrap;
        end
        else
        begin
            rot_dst_full = rot_sum;
        end
        rot_dst = rot_dst_full[AW-1:0];

        if (op_reg.mode == MODE_ROT_L)
        begin
            k_dir = len_dec[AW-1:0];
        end
        else if (length_reg == LW'(1))
        begin
            k_dir = '0;
        end
        else
        begin
            k_dir = AW'(1);
        end

        priority if (op.mode <= MODE_SRCH && length_reg == '0)
        begin
            code_next = ST_EMPTY;
        end
        else if ((op.mode == MODE_WRITE || op.mode == MODE_DEL)
                 && LW'(op.index) >= length_reg)
        begin
            code_next = ST_RANGE;
        end
        else
        begin
            code_next = ST_OK;
        end

        wr_en   = 1'b1;
        priority if (pend_reg)
        begin
            wr_addr = pend_addr_reg;
            wr_data = pend_zero_reg ? '0 : rd_out;
        end
        else if (cmd.wr_entry)
        begin
            wr_addr = {bank_reg, AW'(op_reg.index)};
            wr_data = op_reg.value;
        end
        else if (cmd.swap_a)
        begin
            wr_addr = {bank_reg, hit_dec};
            wr_data = op_reg.value;
        end
        else if (cmd.swap_b)
        begin
            wr_addr = {bank_reg, hit_addr_reg};
            wr_data = prev_reg;
        end
        else
        begin
            wr_en   = 1'b0;
            wr_addr = '0;
            wr_data = '0;
        end
    end

    always_comb
    begin
        stat.mode      = op_reg.mode;
        stat.code      = code_reg;
        stat.mod_done  = mod_done;
        stat.k_zero    = (k_reg == '0);
        stat.rot_last  = (ptr_reg == LW'(DEPTH - 1));
        stat.del_last  = (ptr_reg == length_reg);
        stat.hit       = hit;
        stat.hit_front = (chk_addr_reg == '0);
        stat.srch_end  = !in_range && !chk_reg;
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_ok_reg  <= 1'b0;
            length_reg <= LW'(DEPTH);
            ptr_reg    <= '0;
            bank_reg   <= 1'b0;
            code_reg   <= ST_OK;
            pend_reg   <= 1'b0;
            cap_reg    <= 1'b0;
            chk_reg    <= 1'b0;
            found_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= valid_reg[rd_addr];
            end

            if (cfg_we)
            begin
                length_reg <= (cfg_data > CFG_W'(DEPTH)) ? LW'(DEPTH) : LW'(cfg_data);
            end
            else if (cmd.len_dec)
            begin
                length_reg <= len_dec;
            end

            if (cmd.load)
            begin
                ptr_reg   <= (op.mode == MODE_DEL) ? LW'(op.index) : '0;
                code_reg  <= code_next;
                found_reg <= 1'b0;
            end
            else if (rd_en)
            begin
                ptr_reg <= ptr_reg + LW'(1);
            end

            if (cmd.hit_capture)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.bank_flip)
            begin
                bank_reg <= ~bank_reg;
            end

            // skip the write for the removed entry itself
            pend_reg   <= cmd.rot_read
                          | (cmd.del_step & (!in_range | (ptr_reg != LW'(op_reg.index))));
            cap_reg    <= cmd.del_step & in_range & (ptr_reg == LW'(op_reg.index));
            chk_reg    <= cmd.srch_step & in_range;
            strobe_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
        end
        if (cmd.k_direct)
        begin
            k_reg <= k_dir;
        end
        else if (cmd.k_from_mod)
        begin
            k_reg <= mod_rem;
        end

        pend_zero_reg <= cmd.del_step & !in_range;
        if (cmd.rot_read)
        begin
            pend_addr_reg <= {~bank_reg, rot_dst};
        end
        else
        begin
            pend_addr_reg <= {bank_reg, ptr_dec[AW-1:0]};
        end

        if (cap_reg)
        begin
            removed_reg <= rd_out;
        end
        if (cmd.srch_step)
        begin
            chk_addr_reg <= ptr_reg[AW-1:0];
        end
        // hold the predecessor of a match for the swap
        if (chk_reg && !hit)
        begin
            prev_reg <= rd_out;
        end
        if (cmd.hit_capture)
        begin
            hit_addr_reg <= chk_addr_reg;
            pos_reg      <= (chk_addr_reg == '0) ? '0 : chk_dec;
        end

        if (cmd.finish)
        begin
            result_reg.removed_value <= (op_reg.mode == MODE_DEL && code_reg == ST_OK)
                                        ? removed_reg : '0;
            result_reg.position      <= found_reg ? POS_W'(pos_reg) : '0;
            result_reg.found         <= found_reg;
            result_reg.status        <= code_reg;
        end
    end

    assign result_valid = strobe_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/rlts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlts_ctrl
// Sequencer of the rotating list: decodes the mode and steps the datapath
// through write, rotate, delete and search walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlts_ctrl import rlts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  rlts_stat_t stat,
    output logic       busy,
    output rlts_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_DECODE  = 12'b0000_0000_0010,
        S_MOD     = 12'b0000_0000_0100,
        S_KCHK    = 12'b0000_0000_1000,
        S_ROT     = 12'b0000_0001_0000,
        S_ROT_END = 12'b0000_0010_0000,
        S_DEL     = 12'b0000_0100_0000,
        S_DEL_END = 12'b0000_1000_0000,
        S_SRCH    = 12'b0001_0000_0000,
        S_SWAP_A  = 12'b0010_0000_0000,
        S_SWAP_B  = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.code != ST_OK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (stat.mode)
                        MODE_WRITE:
                        begin
                            cmd.wr_entry = 1'b1;
                            state_next   = S_DONE;
                        end
                        MODE_ROT_R, MODE_ROT_L:
                        begin
                            cmd.k_direct = 1'b1;
                            state_next   = S_KCHK;
                        end
                        MODE_ROT_N:
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end
                        MODE_DEL:  state_next = S_DEL;
                        MODE_SRCH: state_next = S_SRCH;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.k_from_mod = 1'b1;
                    state_next     = S_KCHK;
                end
            end
            S_KCHK:
            begin
                state_next = stat.k_zero ? S_DONE : S_ROT;
            end
            S_ROT:
            begin
                cmd.rot_read = 1'b1;
                if (stat.rot_last)
                begin
                    state_next = S_ROT_END;
                end
            end
            S_ROT_END:
            begin
                cmd.bank_flip = 1'b1;
                state_next    = S_DONE;
            end
            S_DEL:
            begin
                cmd.del_step = 1'b1;
                if (stat.del_last)
                begin
                    state_next = S_DEL_END;
                end
            end
            S_DEL_END:
            begin
                cmd.len_dec = 1'b1;
                state_next  = S_DONE;
            end
            S_SRCH:
            begin
                if (stat.hit)
                begin
                    cmd.hit_capture = 1'b1;
                    state_next      = stat.hit_front ? S_DONE : S_SWAP_A;
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                    if (stat.srch_end)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SWAP_A:
            begin
                cmd.swap_a = 1'b1;
                state_next = S_SWAP_B;
            end
            S_SWAP_B:
            begin
                cmd.swap_b = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== rtl/rotating_list_with_transpose_search_core.sv =====
// ----------------------------------------------------------------------------
// rotating_list_with_transpose_search_core
// List of signed words with write, rotate, delete and transposing search.
//
// Commands: an item on op is taken when start is high and busy is low; busy
// stays high until the result is out. One result per item appears on result
// with result_valid high for exactly one cycle; the receiver cannot stall it,
// and a new start may be given in that same cycle.
// Path of each mode from acceptance to the result:
//   write, error, empty list, unused modes: straight to the result
//   rotate by one (right or left): the bank-to-bank copy, skipped on a
//   one-entry list, where the amount is zero
//   rotate by count: the remainder unit, then the copy; a zero amount
//   skips the copy
//   delete: one entry moved per cycle
//   search: one entry compared per cycle, then a hit not at the front is swapped
// The store has one read and one write port, which sets all walk rates.
// Configuration: cfg_data loads the length (saturated to DEPTH) on a
// cfg_valid/cfg_ready transfer; cfg_ready is high while idle and no
// command is offered on start.
// Reset: length is DEPTH and all entries read as zero; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotating_list_with_transpose_search_core import rlts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rlts_in_t         op,
    output logic             result_valid,
    output rlts_out_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    rlts_cmd_t  cmd;
    rlts_stat_t stat;
    logic       cfg_we;

    // hold a length load off while a command is being offered
    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid & cfg_ready;

    rlts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    rlts_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while a command is still running");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.found) |-> (result.status == ST_OK
                                            && result.removed_value == '0))
        else $error("search hit reported with error status or removed value");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> (!result.found
                                                      && result.position == '0))
        else $error("failed command reported a search hit");

endmodule
